### sv/cir_pkg.sv
// ----------------------------------------------------------------------------
// cir_pkg: shared types, constants and helpers for the contact resolver
// Fixed-point helpers, register indices and the pipeline context record.
// ----------------------------------------------------------------------------
package cir_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CORR_FRAC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEN_SLOP  = 2'd1;

    localparam logic [CFG_DAT_W-1:0] CORR_FRAC_RST = 16'd26214;
    localparam logic [CFG_DAT_W-1:0] PEN_SLOP_RST  = 16'd655;

    // mass share / friction ratio: Q1.16 quotient, 17 bits wide
    localparam int Q_BITS  = 17;
    localparam int DIV_LAT = (Q_BITS + 1) / 2;
    localparam int MU_RW   = 16;
    localparam int LEN_RW  = 32;
    localparam int LEN_LAT = (LEN_RW + 1) / 2;

    typedef enum logic [1:0] {
        OC_RESOLVED = 2'd0,
        OC_STATIC   = 2'd1,
        OC_SEPARATE = 2'd2
    } t_outcome;

    typedef struct packed {
        logic signed [31:0] rvx;
        logic signed [31:0] rvy;
        logic signed [31:0] ivx;
        logic signed [31:0] ivy;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic [30:0]        depth;
        logic [31:0]        ri;
        logic [32:0]        sum;
        logic signed [32:0] dvx;
        logic signed [32:0] dvy;
        logic [15:0]        e;
        logic [15:0]        fref;
        logic [15:0]        finc;
        logic [31:0]        ff;
        logic signed [48:0] pvx;
        logic signed [48:0] pvy;
        t_outcome           outcome;
        logic [35:0]        vmag;
        logic [30:0]        excess;
        logic [37:0]        dn;
        logic [30:0]        corr;
        logic [16:0]        sr;
        logic [16:0]        si;
        logic [37:0]        dr;
        logic [37:0]        di;
        logic [30:0]        cr;
        logic [30:0]        ci;
        logic [38:0]        lim;
        logic signed [54:0] prx;
        logic signed [54:0] pry;
        logic signed [54:0] pix;
        logic signed [54:0] piy;
        logic signed [47:0] crx;
        logic signed [47:0] cry;
        logic signed [47:0] cix;
        logic signed [47:0] ciy;
        logic signed [31:0] sh_rx;
        logic signed [31:0] sh_ry;
        logic signed [31:0] sh_ix;
        logic signed [31:0] sh_iy;
        logic signed [32:0] rlx;
        logic signed [32:0] rly;
        logic signed [48:0] plx;
        logic signed [48:0] ply;
        logic signed [35:0] vn2;
        logic signed [51:0] qx;
        logic signed [51:0] qy;
        logic signed [39:0] tx;
        logic signed [39:0] ty;
        logic               tz;
        logic [3:0]         k;
        logic [30:0]        axs;
        logic [30:0]        ays;
        logic [61:0]        sqx;
        logic [61:0]        sqy;
        logic [62:0]        ssum;
        logic [40:0]        len;
        logic [40:0]        num;
        logic signed [57:0] cpx;
        logic signed [57:0] cpy;
        logic signed [39:0] cx;
        logic signed [39:0] cy;
        logic signed [57:0] fxr;
        logic signed [57:0] fyr;
        logic signed [57:0] fxi;
        logic signed [57:0] fyi;
    } t_ctx;

    // arithmetic shift right, rounding toward zero
    function automatic logic signed [63:0] trunc_shr(input logic signed [63:0] v,
                                                     input int unsigned sh);
        logic signed [63:0] bias;
        bias = v[63] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
        return (v + bias) >>> sh;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

### sv/cir_frac_div.sv
// ----------------------------------------------------------------------------
// cir_frac_div: pipelined fractional divider
// Restoring division num * 2^16 / den for num <= den, two quotient bits a stage.
// ----------------------------------------------------------------------------
module cir_frac_div #(
    parameter int W = 33
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [W-1:0]              i_num,
    input  logic [W-1:0]              i_den,
    output logic [cir_pkg::Q_BITS-1:0] o_q
);
    import cir_pkg::*;

    localparam int STEPS = Q_BITS;
    localparam int NST   = (STEPS + 1) / 2;

    logic [W:0]       a_rem [NST];
    logic [W-1:0]     a_den [NST];
    logic [STEPS-1:0] a_q   [NST];
    logic [W:0]       n_rem [NST];
    logic [STEPS-1:0] n_q   [NST];
    logic [W:0]       r_rem [NST];
    logic [W-1:0]     r_den [NST];
    logic [STEPS-1:0] r_q   [NST];

    for (genvar g = 0; g < NST; g++) begin : g_stage
        if (g == 0) begin : g_first
            assign a_rem[g] = {1'b0, i_num};
            assign a_den[g] = i_den;
            assign a_q[g]   = '0;
        end else begin : g_next
            assign a_rem[g] = r_rem[g-1];
            assign a_den[g] = r_den[g-1];
            assign a_q[g]   = r_q[g-1];
        end

        always_comb begin
            n_rem[g] = a_rem[g];
            n_q[g]   = a_q[g];
            for (int j = 0; j < 2; j++) begin
                if (2 * g + j < STEPS) begin
                    if (2 * g + j > 0) begin
                        n_rem[g] = n_rem[g] << 1;
                    end
                    if (n_rem[g] >= {1'b0, a_den[g]}) begin
                        n_rem[g] = n_rem[g] - {1'b0, a_den[g]};
                        n_q[g]   = {n_q[g][STEPS-2:0], 1'b1};
                    end else begin
                        n_q[g]   = {n_q[g][STEPS-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= n_rem[g];
                r_den[g] <= a_den[g];
                r_q[g]   <= n_q[g];
            end
        end
    end

    assign o_q = r_q[NST-1];

endmodule

### sv/cir_isqrt.sv
// ----------------------------------------------------------------------------
// cir_isqrt: pipelined integer square root
// Digit-by-digit floor square root, two result bits a stage.
// ----------------------------------------------------------------------------
module cir_isqrt #(
    parameter int RW = 16
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [2*RW-1:0] i_val,
    output logic [RW-1:0]   o_root
);
    import cir_pkg::*;

    localparam int WR  = 2 * RW + 1;
    localparam int NST = (RW + 1) / 2;

    logic [WR-1:0] a_rem  [NST];
    logic [RW-1:0] a_root [NST];
    logic [WR-1:0] n_rem  [NST];
    logic [RW-1:0] n_root [NST];
    logic [WR-1:0] r_rem  [NST];
    logic [RW-1:0] r_root [NST];

    for (genvar g = 0; g < NST; g++) begin : g_stage
        if (g == 0) begin : g_first
            assign a_rem[g]  = {1'b0, i_val};
            assign a_root[g] = '0;
        end else begin : g_next
            assign a_rem[g]  = r_rem[g-1];
            assign a_root[g] = r_root[g-1];
        end

        always_comb begin
            logic [WR-1:0] trial;
            int            bi;
            n_rem[g]  = a_rem[g];
            n_root[g] = a_root[g];
            for (int j = 0; j < 2; j++) begin
                bi = RW - 1 - (2 * g + j);
                if (bi >= 0) begin
                    trial = (WR'(n_root[g]) << (bi + 1)) + (WR'(1) << (2 * bi));
                    if (n_rem[g] >= trial) begin
                        n_rem[g]      = n_rem[g] - trial;
                        n_root[g][bi] = 1'b1;
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem[g];
                r_root[g] <= n_root[g];
            end
        end
    end

    assign o_root = r_root[NST-1];

endmodule

### sv/contact_impulse_resolver.sv
// ----------------------------------------------------------------------------
// contact_impulse_resolver: 2D contact impulse with Coulomb friction
// One contact per cycle from input beat to output beat while the output is not stalled.
// Pipeline depth is set by the share and ratio dividers and the tangent-length root.
// The whole pipeline stalls only while the output holds an untaken beat.
// Synchronous active-low reset clears the valid bits and loads the two registers with their reset values.
// ----------------------------------------------------------------------------
module contact_impulse_resolver (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [31:0]              i_ref_vel_x,
    input  logic signed [31:0]              i_ref_vel_y,
    input  logic signed [31:0]              i_inc_vel_x,
    input  logic signed [31:0]              i_inc_vel_y,
    input  logic signed [15:0]              i_normal_x,
    input  logic signed [15:0]              i_normal_y,
    input  logic [30:0]                     i_depth,
    input  logic [31:0]                     i_ref_inv_mass,
    input  logic [31:0]                     i_inc_inv_mass,
    input  logic [31:0]                     i_bounciness_pair,
    input  logic [31:0]                     i_friction_pair,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [31:0]              o_new_ref_vel_x,
    output logic signed [31:0]              o_new_ref_vel_y,
    output logic signed [31:0]              o_new_inc_vel_x,
    output logic signed [31:0]              o_new_inc_vel_y,
    output logic signed [31:0]              o_ref_shift_x,
    output logic signed [31:0]              o_ref_shift_y,
    output logic signed [31:0]              o_inc_shift_x,
    output logic signed [31:0]              o_inc_shift_y,
    output logic [1:0]                      o_outcome,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [cir_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cir_pkg::CFG_DAT_W-1:0]   i_cfg_data
);
    import cir_pkg::*;

    localparam int S_IN   = 1;
    localparam int S_PROD = 2;
    localparam int S_VN   = 3;
    localparam int S_DN   = 4;
    localparam int S_MRG  = S_IN + DIV_LAT;
    localparam int S_IMP  = S_MRG + 1;
    localparam int S_IMPP = S_IMP + 1;
    localparam int S_NRM  = S_IMPP + 1;
    localparam int S_REL  = S_NRM + 1;
    localparam int S_RELP = S_REL + 1;
    localparam int S_VN2  = S_RELP + 1;
    localparam int S_VN2P = S_VN2 + 1;
    localparam int S_TAN  = S_VN2P + 1;
    localparam int S_ABS  = S_TAN + 1;
    localparam int S_SQ   = S_ABS + 1;
    localparam int S_SSUM = S_SQ + 1;
    localparam int S_ROOT = S_SSUM + LEN_LAT;
    localparam int S_LEN  = S_ROOT + 1;
    localparam int S_RAT  = S_LEN + DIV_LAT;
    localparam int S_CP   = S_RAT + 1;
    localparam int S_CX   = S_CP + 1;
    localparam int S_CXP  = S_CX + 1;
    localparam int S_OUT  = S_CXP + 1;

    logic [15:0]      r_cf;
    logic [15:0]      r_slop;
    logic             w_en;
    logic [S_OUT:1]   r_v;
    t_ctx             r_c [1:S_OUT];
    t_ctx             n_c [1:S_OUT];
    logic [Q_BITS-1:0] w_share;
    logic [Q_BITS-1:0] w_ratio;
    logic [MU_RW-1:0]  w_mu;
    logic [LEN_RW-1:0] w_root;

    assign w_en        = ~r_v[S_OUT] | i_ready;
    assign o_ready     = w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cf   <= CORR_FRAC_RST;
            r_slop <= PEN_SLOP_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CORR_FRAC: r_cf   <= i_cfg_data;
                CFG_PEN_SLOP:  r_slop <= i_cfg_data;
                default: ;
            endcase
        end
    end

    cir_frac_div #(.W(33)) u_share_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num ({1'b0, r_c[S_IN].ri}),
        .i_den (r_c[S_IN].sum),
        .o_q   (w_share)
    );

    cir_isqrt #(.RW(MU_RW)) u_mu_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_val  (r_c[S_PROD].ff),
        .o_root (w_mu)
    );

    cir_isqrt #(.RW(LEN_RW)) u_len_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_val  ({1'b0, r_c[S_SSUM].ssum}),
        .o_root (w_root)
    );

    cir_frac_div #(.W(41)) u_ratio_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_c[S_LEN].num),
        .i_den (r_c[S_LEN].len),
        .o_q   (w_ratio)
    );

    always_comb begin
        logic signed [49:0] vn;
        logic signed [49:0] neg;
        logic [52:0]        dn_p;
        logic [46:0]        corr_p;
        logic [54:0]        dr_p;
        logic [54:0]        di_p;
        logic [47:0]        cr_p;
        logic [47:0]        ci_p;
        logic [53:0]        lim_p;
        logic [39:0]        ax;
        logic [39:0]        ay;
        logic [39:0]        m;
        logic [3:0]         kk;
        logic [40:0]        len_v;
        logic               skip;

        for (int i = 2; i <= S_OUT; i++) begin
            n_c[i] = r_c[i-1];
        end

        // capture
        n_c[S_IN]       = r_c[S_IN];
        n_c[S_IN].rvx   = i_ref_vel_x;
        n_c[S_IN].rvy   = i_ref_vel_y;
        n_c[S_IN].ivx   = i_inc_vel_x;
        n_c[S_IN].ivy   = i_inc_vel_y;
        n_c[S_IN].nx    = i_normal_x;
        n_c[S_IN].ny    = i_normal_y;
        n_c[S_IN].depth = i_depth;
        n_c[S_IN].ri    = i_ref_inv_mass;
        n_c[S_IN].sum   = {1'b0, i_ref_inv_mass} + {1'b0, i_inc_inv_mass};
        n_c[S_IN].dvx   = 33'(i_inc_vel_x) - 33'(i_ref_vel_x);
        n_c[S_IN].dvy   = 33'(i_inc_vel_y) - 33'(i_ref_vel_y);
        n_c[S_IN].e     = (i_bounciness_pair[15:0] < i_bounciness_pair[31:16]) ?
                          i_bounciness_pair[15:0] : i_bounciness_pair[31:16];
        n_c[S_IN].fref  = i_friction_pair[15:0];
        n_c[S_IN].finc  = i_friction_pair[31:16];

        // relative normal velocity and friction products
        n_c[S_PROD].ff  = r_c[S_IN].fref * r_c[S_IN].finc;
        n_c[S_PROD].pvx = r_c[S_IN].dvx * r_c[S_IN].nx;
        n_c[S_PROD].pvy = r_c[S_IN].dvy * r_c[S_IN].ny;

        // classify
        vn  = 50'(r_c[S_PROD].pvx) + 50'(r_c[S_PROD].pvy);
        neg = -vn;
        if (r_c[S_PROD].sum == '0) begin
            n_c[S_VN].outcome = OC_STATIC;
        end else if (vn > 0) begin
            n_c[S_VN].outcome = OC_SEPARATE;
        end else begin
            n_c[S_VN].outcome = OC_RESOLVED;
        end
        n_c[S_VN].vmag   = (n_c[S_VN].outcome == OC_RESOLVED) ? neg[49:14] : '0;
        n_c[S_VN].excess = (r_c[S_PROD].depth > {15'd0, r_slop}) ?
                           r_c[S_PROD].depth - {15'd0, r_slop} : '0;

        // normal impulse and correction magnitude
        dn_p           = r_c[S_VN].vmag * (17'd32768 + {1'b0, r_c[S_VN].e});
        n_c[S_DN].dn   = dn_p[52:15];
        corr_p         = r_c[S_VN].excess * r_cf;
        n_c[S_DN].corr = corr_p[46:16];

        // mass shares and friction limit
        n_c[S_IMP].sr  = w_share;
        n_c[S_IMP].si  = 17'd65536 - w_share;
        dr_p           = r_c[S_MRG].dn * w_share;
        di_p           = r_c[S_MRG].dn * (17'd65536 - w_share);
        n_c[S_IMP].dr  = dr_p[53:16];
        n_c[S_IMP].di  = di_p[53:16];
        cr_p           = r_c[S_MRG].corr * w_share;
        ci_p           = r_c[S_MRG].corr * (17'd65536 - w_share);
        n_c[S_IMP].cr  = cr_p[46:16];
        n_c[S_IMP].ci  = ci_p[46:16];
        lim_p          = r_c[S_MRG].dn * w_mu;
        n_c[S_IMP].lim = lim_p[53:15];

        n_c[S_IMPP].prx = $signed({1'b0, r_c[S_IMP].dr}) * r_c[S_IMP].nx;
        n_c[S_IMPP].pry = $signed({1'b0, r_c[S_IMP].dr}) * r_c[S_IMP].ny;
        n_c[S_IMPP].pix = $signed({1'b0, r_c[S_IMP].di}) * r_c[S_IMP].nx;
        n_c[S_IMPP].piy = $signed({1'b0, r_c[S_IMP].di}) * r_c[S_IMP].ny;
        n_c[S_IMPP].crx = $signed({1'b0, r_c[S_IMP].cr}) * r_c[S_IMP].nx;
        n_c[S_IMPP].cry = $signed({1'b0, r_c[S_IMP].cr}) * r_c[S_IMP].ny;
        n_c[S_IMPP].cix = $signed({1'b0, r_c[S_IMP].ci}) * r_c[S_IMP].nx;
        n_c[S_IMPP].ciy = $signed({1'b0, r_c[S_IMP].ci}) * r_c[S_IMP].ny;

        // apply normal impulse, position shifts
        skip = (r_c[S_IMPP].outcome != OC_RESOLVED);
        n_c[S_NRM].rvx = sat32(64'(r_c[S_IMPP].rvx) - trunc_shr(64'(r_c[S_IMPP].prx), 14));
        n_c[S_NRM].rvy = sat32(64'(r_c[S_IMPP].rvy) - trunc_shr(64'(r_c[S_IMPP].pry), 14));
        n_c[S_NRM].ivx = sat32(64'(r_c[S_IMPP].ivx) + trunc_shr(64'(r_c[S_IMPP].pix), 14));
        n_c[S_NRM].ivy = sat32(64'(r_c[S_IMPP].ivy) + trunc_shr(64'(r_c[S_IMPP].piy), 14));
        if (skip) begin
            n_c[S_NRM].sh_rx = '0;
            n_c[S_NRM].sh_ry = '0;
            n_c[S_NRM].sh_ix = '0;
            n_c[S_NRM].sh_iy = '0;
        end else begin
            n_c[S_NRM].sh_rx = sat32(trunc_shr(-64'(r_c[S_IMPP].crx), 14));
            n_c[S_NRM].sh_ry = sat32(trunc_shr(-64'(r_c[S_IMPP].cry), 14));
            n_c[S_NRM].sh_ix = sat32(trunc_shr(64'(r_c[S_IMPP].cix), 14));
            n_c[S_NRM].sh_iy = sat32(trunc_shr(64'(r_c[S_IMPP].ciy), 14));
        end

        // tangent
        n_c[S_REL].rlx  = 33'(r_c[S_NRM].ivx) - 33'(r_c[S_NRM].rvx);
        n_c[S_REL].rly  = 33'(r_c[S_NRM].ivy) - 33'(r_c[S_NRM].rvy);
        n_c[S_RELP].plx = r_c[S_REL].rlx * r_c[S_REL].nx;
        n_c[S_RELP].ply = r_c[S_REL].rly * r_c[S_REL].ny;
        n_c[S_VN2].vn2  = 36'(trunc_shr(64'(r_c[S_RELP].plx) + 64'(r_c[S_RELP].ply), 14));
        n_c[S_VN2P].qx  = r_c[S_VN2].vn2 * r_c[S_VN2].nx;
        n_c[S_VN2P].qy  = r_c[S_VN2].vn2 * r_c[S_VN2].ny;
        n_c[S_TAN].tx   = 40'(64'(r_c[S_VN2P].rlx) - trunc_shr(64'(r_c[S_VN2P].qx), 14));
        n_c[S_TAN].ty   = 40'(64'(r_c[S_VN2P].rly) - trunc_shr(64'(r_c[S_VN2P].qy), 14));

        // tangent length: bring both components under 2^31
        ax = r_c[S_TAN].tx[39] ? 40'(-r_c[S_TAN].tx) : 40'(r_c[S_TAN].tx);
        ay = r_c[S_TAN].ty[39] ? 40'(-r_c[S_TAN].ty) : 40'(r_c[S_TAN].ty);
        m  = ax | ay;
        kk = '0;
        for (int b = 31; b < 40; b++) begin
            if (m[b]) begin
                kk = 4'(b - 30);
            end
        end
        n_c[S_ABS].tz  = (r_c[S_TAN].tx == '0) && (r_c[S_TAN].ty == '0);
        n_c[S_ABS].k   = kk;
        n_c[S_ABS].axs = 31'(ax >> kk);
        n_c[S_ABS].ays = 31'(ay >> kk);

        n_c[S_SQ].sqx   = r_c[S_ABS].axs * r_c[S_ABS].axs;
        n_c[S_SQ].sqy   = r_c[S_ABS].ays * r_c[S_ABS].ays;
        n_c[S_SSUM].ssum = {1'b0, r_c[S_SQ].sqx} + {1'b0, r_c[S_SQ].sqy};

        len_v          = 41'(w_root) << r_c[S_ROOT].k;
        n_c[S_LEN].len = len_v;
        n_c[S_LEN].num = (41'(r_c[S_ROOT].lim) < len_v) ? 41'(r_c[S_ROOT].lim) : len_v;

        // friction impulse
        n_c[S_CP].cpx  = r_c[S_RAT].tx * $signed({1'b0, w_ratio});
        n_c[S_CP].cpy  = r_c[S_RAT].ty * $signed({1'b0, w_ratio});
        n_c[S_CX].cx   = 40'(trunc_shr(64'(r_c[S_CP].cpx), 16));
        n_c[S_CX].cy   = 40'(trunc_shr(64'(r_c[S_CP].cpy), 16));
        n_c[S_CXP].fxr = r_c[S_CX].cx * $signed({1'b0, r_c[S_CX].sr});
        n_c[S_CXP].fyr = r_c[S_CX].cy * $signed({1'b0, r_c[S_CX].sr});
        n_c[S_CXP].fxi = r_c[S_CX].cx * $signed({1'b0, r_c[S_CX].si});
        n_c[S_CXP].fyi = r_c[S_CX].cy * $signed({1'b0, r_c[S_CX].si});

        if (!r_c[S_CXP].tz && (r_c[S_CXP].outcome == OC_RESOLVED)) begin
            n_c[S_OUT].rvx = sat32(64'(r_c[S_CXP].rvx) + trunc_shr(64'(r_c[S_CXP].fxr), 16));
            n_c[S_OUT].rvy = sat32(64'(r_c[S_CXP].rvy) + trunc_shr(64'(r_c[S_CXP].fyr), 16));
            n_c[S_OUT].ivx = sat32(64'(r_c[S_CXP].ivx) - trunc_shr(64'(r_c[S_CXP].fxi), 16));
            n_c[S_OUT].ivy = sat32(64'(r_c[S_CXP].ivy) - trunc_shr(64'(r_c[S_CXP].fyi), 16));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[S_OUT-1:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 1; i <= S_OUT; i++) begin
                r_c[i] <= n_c[i];
            end
        end
    end

    assign o_valid         = r_v[S_OUT];
    assign o_new_ref_vel_x = r_c[S_OUT].rvx;
    assign o_new_ref_vel_y = r_c[S_OUT].rvy;
    assign o_new_inc_vel_x = r_c[S_OUT].ivx;
    assign o_new_inc_vel_y = r_c[S_OUT].ivy;
    assign o_ref_shift_x   = r_c[S_OUT].sh_rx;
    assign o_ref_shift_y   = r_c[S_OUT].sh_ry;
    assign o_inc_shift_x   = r_c[S_OUT].sh_ix;
    assign o_inc_shift_y   = r_c[S_OUT].sh_iy;
    assign o_outcome       = r_c[S_OUT].outcome;

endmodule

### sv/cir_checker.sv
// ----------------------------------------------------------------------------
// cir_checker: port-level checks for the contact resolver
// Stall behaviour of the output beat and shifts of skipped contacts.
// ----------------------------------------------------------------------------
module cir_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [31:0] o_new_ref_vel_x,
    input logic signed [31:0] o_ref_shift_x,
    input logic signed [31:0] o_ref_shift_y,
    input logic signed [31:0] o_inc_shift_x,
    input logic signed [31:0] o_inc_shift_y,
    input logic [1:0]         o_outcome
);
    import cir_pkg::*;

    // skipped contacts move nothing
    a_skip_no_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_outcome != OC_RESOLVED)) |->
        (o_ref_shift_x == 0 && o_ref_shift_y == 0 &&
         o_inc_shift_x == 0 && o_inc_shift_y == 0))
        else $error("skipped contact carries a shift");

    // an empty output slot never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input blocked with empty output");

    // input ready follows the output side
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !o_ready)
        else $error("input taken while output stalled");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=>
        (o_valid && $stable(o_outcome) && $stable(o_new_ref_vel_x)))
        else $error("stalled output beat changed");

endmodule

bind contact_impulse_resolver cir_checker u_cir_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_new_ref_vel_x (o_new_ref_vel_x),
    .o_ref_shift_x   (o_ref_shift_x),
    .o_ref_shift_y   (o_ref_shift_y),
    .o_inc_shift_x   (o_inc_shift_x),
    .o_inc_shift_y   (o_inc_shift_y),
    .o_outcome       (o_outcome)
);

### tb/contact_checker.sv
// ----------------------------------------------------------------------------
// contact_checker: impulse predictor and result scoreboard
// Watches the contact, result and register channels, computes the expected
// velocities, shifts and outcome for every accepted contact, and compares.
// ----------------------------------------------------------------------------
module contact_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          o_ready,
    input  logic signed [31:0]            i_ref_vel_x,
    input  logic signed [31:0]            i_ref_vel_y,
    input  logic signed [31:0]            i_inc_vel_x,
    input  logic signed [31:0]            i_inc_vel_y,
    input  logic signed [15:0]            i_normal_x,
    input  logic signed [15:0]            i_normal_y,
    input  logic [30:0]                   i_depth,
    input  logic [31:0]                   i_ref_inv_mass,
    input  logic [31:0]                   i_inc_inv_mass,
    input  logic [31:0]                   i_bounciness_pair,
    input  logic [31:0]                   i_friction_pair,
    input  logic                          o_valid,
    input  logic                          i_ready,
    input  logic signed [31:0]            o_new_ref_vel_x,
    input  logic signed [31:0]            o_new_ref_vel_y,
    input  logic signed [31:0]            o_new_inc_vel_x,
    input  logic signed [31:0]            o_new_inc_vel_y,
    input  logic signed [31:0]            o_ref_shift_x,
    input  logic signed [31:0]            o_ref_shift_y,
    input  logic signed [31:0]            o_inc_shift_x,
    input  logic signed [31:0]            o_inc_shift_y,
    input  logic [1:0]                    o_outcome,
    input  logic                          i_cfg_valid,
    input  logic                          o_cfg_ready,
    input  logic [cir_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cir_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);
    import cir_pkg::*;

    typedef struct {
        logic signed [31:0] rvx, rvy, ivx, ivy, srx, sry, six, siy;
        t_outcome           oc;
    } t_contact_res;

    t_contact_res    expected_q[$];
    logic [15:0]     frac_reg;
    logic [15:0]     slop_reg;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint unsigned root64(longint unsigned s);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b >>= 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic t_contact_res resolve_contact();
        t_contact_res    r;
        longint          rvx, rvy, ivx, ivy, nx, ny, vn, dr, di, tx, ty, vn2;
        longint          rlx, rly, cx, cy;
        longint unsigned depth, ri, ii, sum, e, vmag, dn, sr, si, ax, ay, len;
        longint unsigned mu, lim, rr, excess, corr, cr, ci, fr, fi;
        int              k;
        rvx = longint'(i_ref_vel_x); rvy = longint'(i_ref_vel_y);
        ivx = longint'(i_inc_vel_x); ivy = longint'(i_inc_vel_y);
        nx = longint'(i_normal_x); ny = longint'(i_normal_y);
        depth = 64'(i_depth); ri = 64'(i_ref_inv_mass); ii = 64'(i_inc_inv_mass);
        sum = ri + ii;
        r.srx = 0; r.sry = 0; r.six = 0; r.siy = 0;
        r.oc = OC_RESOLVED;
        if (sum == 0) begin
            r.oc = OC_STATIC;
        end else begin
            vn = (ivx - rvx) * nx + (ivy - rvy) * ny;
            if (vn > 0) begin
                r.oc = OC_SEPARATE;
            end else begin
                e = 64'((i_bounciness_pair[15:0] < i_bounciness_pair[31:16]) ?
                        i_bounciness_pair[15:0] : i_bounciness_pair[31:16]);
                vmag = longint'(-vn) >> 14;
                dn = (vmag * (32768 + e)) >> 15;
                sr = (ri << 16) / sum;
                si = 65536 - sr;
                dr = longint'((dn * sr) >> 16);
                di = longint'((dn * si) >> 16);
                rvx = clamp32(rvx - dr * nx / 16384);
                rvy = clamp32(rvy - dr * ny / 16384);
                ivx = clamp32(ivx + di * nx / 16384);
                ivy = clamp32(ivy + di * ny / 16384);
                rlx = ivx - rvx;
                rly = ivy - rvy;
                vn2 = (rlx * nx + rly * ny) / 16384;
                tx = rlx - vn2 * nx / 16384;
                ty = rly - vn2 * ny / 16384;
                if (tx != 0 || ty != 0) begin
                    ax = tx < 0 ? -tx : tx;
                    ay = ty < 0 ? -ty : ty;
                    k = 0;
                    while (ax >= 64'h80000000 || ay >= 64'h80000000) begin
                        ax >>= 1; ay >>= 1; k++;
                    end
                    len = root64(ax * ax + ay * ay) << k;
                    fr = 64'(i_friction_pair[15:0]);
                    fi = 64'(i_friction_pair[31:16]);
                    mu = root64(fr * fi);
                    lim = (dn * mu) >> 15;
                    rr = (len < lim) ? 65536 : (lim << 16) / len;
                    cx = tx * longint'(rr) / 65536;
                    cy = ty * longint'(rr) / 65536;
                    rvx = clamp32(rvx + cx * longint'(sr) / 65536);
                    rvy = clamp32(rvy + cy * longint'(sr) / 65536);
                    ivx = clamp32(ivx - cx * longint'(si) / 65536);
                    ivy = clamp32(ivy - cy * longint'(si) / 65536);
                end
                excess = depth > 64'(slop_reg) ? depth - 64'(slop_reg) : 0;
                corr = (excess * 64'(frac_reg)) >> 16;
                cr = (corr * sr) >> 16;
                ci = (corr * si) >> 16;
                r.srx = 32'(clamp32(-(longint'(cr) * nx) / 16384));
                r.sry = 32'(clamp32(-(longint'(cr) * ny) / 16384));
                r.six = 32'(clamp32(longint'(ci) * nx / 16384));
                r.siy = 32'(clamp32(longint'(ci) * ny / 16384));
            end
        end
        r.rvx = 32'(rvx); r.rvy = 32'(rvy); r.ivx = 32'(ivx); r.ivy = 32'(ivy);
        return r;
    endfunction

    task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_contact_res want;
        if (!i_rst_n) begin
            frac_reg <= CORR_FRAC_RST;
            slop_reg <= PEN_SLOP_RST;
            o_fail_count = 0;
            o_pending <= 0;
        end else begin
            if (i_valid && o_ready) begin
                expected_q.insert(expected_q.size(), resolve_contact());
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_CORR_FRAC) begin
                    frac_reg <= i_cfg_data;
                end else if (i_cfg_index == CFG_PEN_SLOP) begin
                    slop_reg <= i_cfg_data;
                end
            end
            if (o_valid && i_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result beat with no contact outstanding");
                    o_fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    compare_field("new_ref_vel_x", want.rvx, o_new_ref_vel_x);
                    compare_field("new_ref_vel_y", want.rvy, o_new_ref_vel_y);
                    compare_field("new_inc_vel_x", want.ivx, o_new_inc_vel_x);
                    compare_field("new_inc_vel_y", want.ivy, o_new_inc_vel_y);
                    compare_field("ref_shift_x", want.srx, o_ref_shift_x);
                    compare_field("ref_shift_y", want.sry, o_ref_shift_y);
                    compare_field("inc_shift_x", want.six, o_inc_shift_x);
                    compare_field("inc_shift_y", want.siy, o_inc_shift_y);
                    compare_field("outcome", 32'(want.oc), 32'(o_outcome));
                end
            end
            o_pending <= expected_q.size();
        end
    end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: contact impulse resolver testbench
// Drives directed and random contacts with random gaps and output stalls,
// walks the register settings, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import cir_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic signed [31:0]   i_ref_vel_x = '0, i_ref_vel_y = '0;
    logic signed [31:0]   i_inc_vel_x = '0, i_inc_vel_y = '0;
    logic signed [15:0]   i_normal_x = '0, i_normal_y = '0;
    logic [30:0]          i_depth = '0;
    logic [31:0]          i_ref_inv_mass = '0, i_inc_inv_mass = '0;
    logic [31:0]          i_bounciness_pair = '0, i_friction_pair = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic signed [31:0]   o_new_ref_vel_x, o_new_ref_vel_y;
    logic signed [31:0]   o_new_inc_vel_x, o_new_inc_vel_y;
    logic signed [31:0]   o_ref_shift_x, o_ref_shift_y, o_inc_shift_x, o_inc_shift_y;
    logic [1:0]           o_outcome;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;
    int                   fail_count;
    int                   pending;
    int                   idle_cycles = 0;
    bit                   long_hold = 1'b0;
    bit                   hold_done = 1'b0;

    always #1 i_clk = ~i_clk;

    contact_impulse_resolver dut (.*);

    contact_checker u_checker (.*, .o_fail_count(fail_count), .o_pending(pending));

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (long_hold && !hold_done) begin
                i_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_done = 1'b1;
            end
            n = $urandom_range(0, 99);
            if (n < 40) begin
                i_ready <= 1'b1;
            end else if (n < 95) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(0, 3)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b0;
                repeat ($urandom_range(10, 60)) @(posedge i_clk);
            end
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 20) - 10;
            3: return 32'($signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_contact(logic [31:0] rvx, logic [31:0] rvy, logic [31:0] ivx,
                                logic [31:0] ivy, logic [15:0] nx, logic [15:0] ny,
                                logic [30:0] dep, logic [31:0] rim, logic [31:0] iim,
                                logic [31:0] bp, logic [31:0] fp);
        i_valid <= 1'b1;
        i_ref_vel_x <= rvx; i_ref_vel_y <= rvy;
        i_inc_vel_x <= ivx; i_inc_vel_y <= ivy;
        i_normal_x <= nx; i_normal_y <= ny;
        i_depth <= dep;
        i_ref_inv_mass <= rim; i_inc_inv_mass <= iim;
        i_bounciness_pair <= bp; i_friction_pair <= fp;
        do @(posedge i_clk); while (!o_ready);
        if ($urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(5, 40)) @(posedge i_clk);
            end else begin
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end
        end
    endtask

    function automatic int root_of(int a);
        int s;
        s = 0;
        while ((s + 1) * (s + 1) <= 16384 * 16384 - a * a) s++;
        return s;
    endfunction

    task automatic random_contact();
        logic [15:0] nx, ny;
        logic [31:0] rim, iim, rvx, rvy, ivx, ivy;
        int          sel;
        int          ang;
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
            ang = $urandom_range(0, 16384);
            nx = 16'(ang);
            ny = 16'($urandom_range(0, 1) ? root_of(ang) : -root_of(ang));
            if ($urandom_range(0, 1)) nx = -nx;
        end else begin
            nx = 16'($urandom); ny = 16'($urandom);
        end
        rim = $urandom_range(0, 9) == 0 ? 32'd0 : pick_word();
        iim = $urandom_range(0, 9) == 0 ? 32'd0 : pick_word();
        rvx = pick_word(); rvy = pick_word(); ivx = pick_word(); ivy = pick_word();
        send_contact(rvx, rvy, ivx, ivy, nx, ny, 31'($urandom), rim, iim, $urandom, $urandom);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // extremes and special cases
        send_contact(1, 2, 3, 4, 16384, 0, 5000, 0, 0, 0, 0);
        send_contact(0, 0, 32'h00010000, 0, 16384, 0, 0, 65536, 65536, 0, 0);
        send_contact(32'h00010000, 0, 0, 0, 16384, 0, 31'h7fffffff, 65536, 65536,
                     32'hffffffff, 32'hffffffff);
        send_contact(0, 0, 0, 0, 16384, 0, 100, 65536, 0, 0, 0);
        send_contact(32'h00050000, 32'h00030000, 0, 0, 0, -16384, 70000, 65536, 131072,
                     32'h40004000, 32'h20008000);
        send_contact(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 11585, 11585,
                     31'h7fffffff, 32'hffffffff, 32'hffffffff, 32'h80008000, 32'hffffffff);
        send_contact(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, -16384, 16384,
                     31'h7fffffff, 1, 32'hffffffff, 0, 32'hffffffff);
        send_contact(32'h7fffffff, 0, 32'h80000000, 0, 16'h8000, 16'h7fff, 12345,
                     32'hffffffff, 1, 32'hffff0000, 32'h0000ffff);
        send_contact(0, 32'h7fffffff, 0, 0, 0, 16384, 655, 0, 65536, 0, 32'h80008000);
        send_contact(0, 0, 0, 0, 0, 0, 999, 65536, 65536, 0, 0);
        i_valid <= 1'b0;
        drain();
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(CFG_CORR_FRAC, 16'hffff); write_reg(CFG_PEN_SLOP, 0); end
                1: begin write_reg(CFG_CORR_FRAC, 0); write_reg(CFG_PEN_SLOP, 16'hffff); end
                2: begin write_reg(CFG_CORR_FRAC, CORR_FRAC_RST); write_reg(CFG_UNUSED, 16'h1234); end
                default: begin
                    write_reg(CFG_CORR_FRAC, 16'($urandom));
                    write_reg(CFG_PEN_SLOP, 16'($urandom));
                end
            endcase
            if (ph == 1) long_hold = 1'b1;
            for (int i = 0; i < 257; i++) random_contact();
            i_valid <= 1'b0;
            drain();
        end
        if (fail_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
